FILE: rtl/csot_pkg.sv
`default_nettype none

package csot_pkg;

  // Coordinate width; the difference, square and product widths below follow from it.
  localparam int COORD_BITS = 24;

  // Difference of two coordinates.
  localparam int DIFF_W = COORD_BITS + 1;
  // One squared difference; its magnitude stays below 2^(2*COORD_BITS).
  localparam int SQ1_W  = 2 * COORD_BITS;
  // Sum of three squares; also the signed product width.
  localparam int SQ_W   = 2 * DIFF_W;
  // Signed dot product ac.ab.
  localparam int E_W    = SQ_W + 1;

  // Radii are fixed unsigned Q11.12 fields.
  localparam int RAD_W  = 23;
  localparam int RSUM_W = RAD_W + 1;
  localparam int RSQ_W  = 2 * RSUM_W;

  // Result distance field.
  localparam int DIST_W = 52;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Common width for the final compares.
  localparam int CMP_W = (SQ_W >= DIST_W) ?
                         ((SQ_W >= RSQ_W) ? SQ_W : RSQ_W) :
                         ((DIST_W >= RSQ_W) ? DIST_W : RSQ_W);

  // Payload carried through the divider stages.
  // eq holds the not yet consumed bits of e on top and the quotient below.
  typedef struct packed {
    logic [SQ_W-1:0]  rem;
    logic [SQ_W-1:0]  eq;
    logic [SQ_W-1:0]  e;
    logic [SQ_W-1:0]  f;
    logic [SQ_W-1:0]  base;
    logic [RSQ_W-1:0] rsq;
    logic             interior;
  } csot_div_t;

endpackage

`default_nettype wire

FILE: rtl/capsule_sphere_overlap_test_top.sv
`default_nettype none

// Capsule versus sphere overlap test. Each input beat carries a capsule
// (segment start A, end B, radius) and a sphere (center C, radius) in signed
// Q12.12; each beat yields exactly one output beat with the squared distance
// from C to segment AB (Q28.24, saturated to the field) and a hit flag that is
// set when that distance is no greater than the squared sum of the radii.
// The block is a pipeline that takes one beat per clock while in_stall is low
// and returns results in order. Its stages are four front stages (differences,
// products, dot products, region select), one stage per quotient bit for the
// interior projection term e*e/f (2*COORD_BITS+2 stages, the bulk of the
// pipeline), a subtract stage and the output register. Sustained rate is one
// beat per cycle while out_stall is low.
// Backpressure: while an output beat waits under out_stall the pipeline still
// moves as long as the stage in front of the output register holds a bubble,
// so gaps close up; it freezes only once a result is queued behind the held
// one. in_stall is that freeze condition, combinational in the same cycle.
module capsule_sphere_overlap_test_top (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic signed [csot_pkg::COORD_BITS-1:0] in_seg_start_x,
  input  wire logic signed [csot_pkg::COORD_BITS-1:0] in_seg_start_y,
  input  wire logic signed [csot_pkg::COORD_BITS-1:0] in_seg_start_z,
  input  wire logic signed [csot_pkg::COORD_BITS-1:0] in_seg_end_x,
  input  wire logic signed [csot_pkg::COORD_BITS-1:0] in_seg_end_y,
  input  wire logic signed [csot_pkg::COORD_BITS-1:0] in_seg_end_z,
  input  wire logic signed [csot_pkg::COORD_BITS-1:0] in_ball_center_x,
  input  wire logic signed [csot_pkg::COORD_BITS-1:0] in_ball_center_y,
  input  wire logic signed [csot_pkg::COORD_BITS-1:0] in_ball_center_z,
  input  wire logic        [csot_pkg::RAD_W-1:0]      in_ball_radius,
  input  wire logic        [csot_pkg::RAD_W-1:0]      in_capsule_radius,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic                                        out_hit,
  output logic             [csot_pkg::DIST_W-1:0]     out_dist_sq
);
  import csot_pkg::*;

  // Divider chain: index 0 is the front end's output, SQ_W the last step.
  logic      div_v [SQ_W+1];
  csot_div_t div_d [SQ_W+1];

  logic last_v;   // beat in the stage feeding the output register
  logic out_ld;   // output register may take a new beat
  logic adv;      // all other stages shift

  assign out_ld   = !out_valid || !out_stall;
  // A bubble in front of a held output can be overwritten.
  assign adv      = out_ld || !last_v;
  assign in_stall = !adv;

  csot_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .adv               (adv),
    .in_valid          (in_valid),
    .in_seg_start_x    (in_seg_start_x),
    .in_seg_start_y    (in_seg_start_y),
    .in_seg_start_z    (in_seg_start_z),
    .in_seg_end_x      (in_seg_end_x),
    .in_seg_end_y      (in_seg_end_y),
    .in_seg_end_z      (in_seg_end_z),
    .in_ball_center_x  (in_ball_center_x),
    .in_ball_center_y  (in_ball_center_y),
    .in_ball_center_z  (in_ball_center_z),
    .in_ball_radius    (in_ball_radius),
    .in_capsule_radius (in_capsule_radius),
    .div_valid         (div_v[0]),
    .div_data          (div_d[0])
  );

  // One quotient bit per stage, MSB of e first.
  for (genvar i = 0; i < SQ_W; i++) begin : g_div
    csot_div_step u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .in_v  (div_v[i]),
      .in_d  (div_d[i]),
      .out_v (div_v[i+1]),
      .out_d (div_d[i+1])
    );
  end

  csot_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .out_ld      (out_ld),
    .in_v        (div_v[SQ_W]),
    .in_d        (div_d[SQ_W]),
    .last_v      (last_v),
    .out_valid   (out_valid),
    .out_hit     (out_hit),
    .out_dist_sq (out_dist_sq)
  );

  // Interior beats always enter the divider with 0 < e < f.
  a_interior_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    div_v[0] && div_d[0].interior |-> (div_d[0].e != '0) && (div_d[0].e < div_d[0].f))
    else $error("interior beat with e outside (0, f)");

  // The running remainder stays below the divisor through the last step.
  a_remainder_bound: assert property (@(posedge clk) disable iff (!rst_n)
    div_v[SQ_W] && div_d[SQ_W].interior |-> div_d[SQ_W].rem < div_d[SQ_W].f)
    else $error("divider remainder not below divisor");

  // A held output with a beat queued behind it freezes the divider tail.
  a_freeze_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall && last_v |=> $stable(div_d[SQ_W]) && $stable(div_v[SQ_W]))
    else $error("pipeline moved while output blocked");

endmodule

`default_nettype wire

FILE: rtl/csot_front.sv
`default_nettype none

module csot_front (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                adv,
  input  wire logic                                in_valid,
  input  wire logic signed [csot_pkg::COORD_BITS-1:0] in_seg_start_x,
  input  wire logic signed [csot_pkg::COORD_BITS-1:0] in_seg_start_y,
  input  wire logic signed [csot_pkg::COORD_BITS-1:0] in_seg_start_z,
  input  wire logic signed [csot_pkg::COORD_BITS-1:0] in_seg_end_x,
  input  wire logic signed [csot_pkg::COORD_BITS-1:0] in_seg_end_y,
  input  wire logic signed [csot_pkg::COORD_BITS-1:0] in_seg_end_z,
  input  wire logic signed [csot_pkg::COORD_BITS-1:0] in_ball_center_x,
  input  wire logic signed [csot_pkg::COORD_BITS-1:0] in_ball_center_y,
  input  wire logic signed [csot_pkg::COORD_BITS-1:0] in_ball_center_z,
  input  wire logic        [csot_pkg::RAD_W-1:0]      in_ball_radius,
  input  wire logic        [csot_pkg::RAD_W-1:0]      in_capsule_radius,
  output logic                                     div_valid,
  output csot_pkg::csot_div_t                      div_data
);
  import csot_pkg::*;

  logic signed [COORD_BITS-1:0] pa [3];
  logic signed [COORD_BITS-1:0] pb [3];
  logic signed [COORD_BITS-1:0] pc [3];

  // stage 1: differences
  logic                     v1_r;
  logic signed [DIFF_W-1:0] ab_r [3];
  logic signed [DIFF_W-1:0] ac_r [3];
  logic signed [DIFF_W-1:0] bc_r [3];
  logic [RSUM_W-1:0]        rsum_r;

  // stage 2: products
  logic signed [SQ_W-1:0]   p_abab [3];
  logic signed [SQ_W-1:0]   p_acab [3];
  logic signed [SQ_W-1:0]   p_acac [3];
  logic signed [SQ_W-1:0]   p_bcbc [3];
  logic                     v2_r;
  logic [SQ1_W-1:0]         abab_r [3];
  logic signed [SQ_W-1:0]   acab_r [3];
  logic [SQ1_W-1:0]         acac_r [3];
  logic [SQ1_W-1:0]         bcbc_r [3];
  logic [RSQ_W-1:0]         rsq2_r;

  // stage 3: dot products
  logic                     v3_r;
  logic [SQ_W-1:0]          f_r;
  logic signed [E_W-1:0]    e_r;
  logic [SQ_W-1:0]          acac_sum_r;
  logic [SQ_W-1:0]          bcbc_sum_r;
  logic [RSQ_W-1:0]         rsq3_r;

  // stage 4: region select
  logic                     at_start;
  logic                     at_end;
  logic                     div_valid_r;
  csot_div_t                div_data_r;
  csot_div_t                div_data_nxt;

  always_comb begin
    pa[0] = in_seg_start_x;   pa[1] = in_seg_start_y;   pa[2] = in_seg_start_z;
    pb[0] = in_seg_end_x;     pb[1] = in_seg_end_y;     pb[2] = in_seg_end_z;
    pc[0] = in_ball_center_x; pc[1] = in_ball_center_y; pc[2] = in_ball_center_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        ab_r[k] <= {pb[k][COORD_BITS-1], pb[k]} - {pa[k][COORD_BITS-1], pa[k]};
        ac_r[k] <= {pc[k][COORD_BITS-1], pc[k]} - {pa[k][COORD_BITS-1], pa[k]};
        bc_r[k] <= {pc[k][COORD_BITS-1], pc[k]} - {pb[k][COORD_BITS-1], pb[k]};
      end
      rsum_r <= {1'b0, in_ball_radius} + {1'b0, in_capsule_radius};
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p_abab[k] = ab_r[k] * ab_r[k];
      p_acab[k] = ac_r[k] * ab_r[k];
      p_acac[k] = ac_r[k] * ac_r[k];
      p_bcbc[k] = bc_r[k] * bc_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  // squares are nonnegative and fit in SQ1_W bits
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        abab_r[k] <= p_abab[k][SQ1_W-1:0];
        acab_r[k] <= p_acab[k];
        acac_r[k] <= p_acac[k][SQ1_W-1:0];
        bcbc_r[k] <= p_bcbc[k][SQ1_W-1:0];
      end
      rsq2_r <= rsum_r * rsum_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_r        <= {2'b00, abab_r[0]} + {2'b00, abab_r[1]} + {2'b00, abab_r[2]};
      acac_sum_r <= {2'b00, acac_r[0]} + {2'b00, acac_r[1]} + {2'b00, acac_r[2]};
      bcbc_sum_r <= {2'b00, bcbc_r[0]} + {2'b00, bcbc_r[1]} + {2'b00, bcbc_r[2]};
      e_r        <= {acab_r[0][SQ_W-1], acab_r[0]} + {acab_r[1][SQ_W-1], acab_r[1]}
                  + {acab_r[2][SQ_W-1], acab_r[2]};
      rsq3_r     <= rsq2_r;
    end
  end

  // e <= 0: nearest point is the start; e >= f: the end; else interior
  always_comb begin
    at_start = e_r[E_W-1] || (e_r == '0);
    at_end   = !at_start && (f_r <= e_r[SQ_W-1:0]);

    div_data_nxt          = '0;
    div_data_nxt.rem      = '0;
    div_data_nxt.eq       = e_r[SQ_W-1:0];
    div_data_nxt.e        = e_r[SQ_W-1:0];
    div_data_nxt.f        = f_r;
    div_data_nxt.base     = at_end ? bcbc_sum_r : acac_sum_r;
    div_data_nxt.rsq      = rsq3_r;
    div_data_nxt.interior = !at_start && !at_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_valid_r <= 1'b0;
    end else if (adv) begin
      div_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_data_r <= div_data_nxt;
    end
  end

  assign div_valid = div_valid_r;
  assign div_data  = div_data_r;

endmodule

`default_nettype wire

FILE: rtl/csot_div_step.sv
`default_nettype none

module csot_div_step (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                adv,
  input  wire logic                in_v,
  input  wire csot_pkg::csot_div_t in_d,
  output logic                     out_v,
  output csot_pkg::csot_div_t      out_d
);
  import csot_pkg::*;

  // One bit of e*e/f: rem = 2*rem + bit*e, then subtract f up to twice.
  logic [SQ_W+2:0] t0;
  logic [SQ_W+2:0] t1;
  logic [SQ_W+2:0] t2;
  logic [SQ_W-1:0] eq_shift;
  csot_div_t       out_d_nxt;
  logic            out_v_r;
  csot_div_t       out_d_r;

  always_comb begin
    t0 = {2'b00, in_d.rem, 1'b0}
       + (in_d.eq[SQ_W-1] ? {3'b000, in_d.e} : {(SQ_W+3){1'b0}});
    t1 = t0 - {3'b000, in_d.f};
    t2 = t0 - {2'b00, in_d.f, 1'b0};
    eq_shift = {in_d.eq[SQ_W-2:0], 1'b0};

    out_d_nxt = in_d;
    if (!t2[SQ_W+2]) begin
      out_d_nxt.rem = t2[SQ_W-1:0];
      out_d_nxt.eq  = eq_shift + SQ_W'(2);
    end else if (!t1[SQ_W+2]) begin
      out_d_nxt.rem = t1[SQ_W-1:0];
      out_d_nxt.eq  = eq_shift + SQ_W'(1);
    end else begin
      out_d_nxt.rem = t0[SQ_W-1:0];
      out_d_nxt.eq  = eq_shift;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_d_r <= out_d_nxt;
    end
  end

  assign out_v = out_v_r;
  assign out_d = out_d_r;

endmodule

`default_nettype wire

FILE: rtl/csot_back.sv
`default_nettype none

module csot_back (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   adv,
  input  wire logic                   out_ld,
  input  wire logic                   in_v,
  input  wire csot_pkg::csot_div_t    in_d,
  output logic                        last_v,
  output logic                        out_valid,
  output logic                        out_hit,
  output logic [csot_pkg::DIST_W-1:0] out_dist_sq
);
  import csot_pkg::*;

  logic              v_r;
  logic [SQ_W-1:0]   d_r;
  logic [RSQ_W-1:0]  rsq_r;
  logic [CMP_W-1:0]  d_ext;
  logic              hit_nxt;
  logic [DIST_W-1:0] dist_nxt;
  logic              out_valid_r;
  logic              out_hit_r;
  logic [DIST_W-1:0] out_dist_sq_r;

  // quotient sits in eq once all bits of e are consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r   <= in_d.base - (in_d.interior ? in_d.eq : {SQ_W{1'b0}});
      rsq_r <= in_d.rsq;
    end
  end

  always_comb begin
    d_ext    = CMP_W'(d_r);
    hit_nxt  = d_ext <= CMP_W'(rsq_r);
    dist_nxt = (d_ext > CMP_W'(DIST_MAX)) ? DIST_MAX : d_ext[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_hit_r     <= hit_nxt;
      out_dist_sq_r <= dist_nxt;
    end
  end

  assign last_v      = v_r;
  assign out_valid   = out_valid_r;
  assign out_hit     = out_hit_r;
  assign out_dist_sq = out_dist_sq_r;

endmodule

`default_nettype wire
